FILE: src/isotp_pkg.sv
// shared types and constants for the iso-tp transmit segmenter
package isotp_pkg;

    // frame kind tracked between beats
    typedef enum logic [3:0] {
        K_IDLE   = 4'b0001,
        K_SINGLE = 4'b0010,
        K_FIRST  = 4'b0100,
        K_CONSEC = 4'b1000
    } t_kind;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD      = 1'b1;
    localparam int CFG_DATA_W = 11;

    // frame geometry
    localparam int FRAME_BYTES = 8;
    localparam int BUF_DEPTH   = FRAME_BYTES - 1;
    localparam int FF_DATA     = FRAME_BYTES - 2;
    localparam int FILL_W      = 3;
    localparam int LEN_W       = 12;
    localparam int SEQ_W       = 4;
    localparam int ID_W        = 11;

    // protocol control nibbles
    localparam logic [3:0] PCI_SF = 4'h0;
    localparam logic [3:0] PCI_FF = 4'h1;
    localparam logic [3:0] PCI_CF = 4'h2;

    // reset values
    localparam logic [ID_W-1:0]  FRAME_ID_RST = 11'h703;
    localparam logic [7:0]       PAD_RST      = 8'h00;
    localparam logic [SEQ_W-1:0] SEQ_RST      = 4'h1;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 80;

endpackage

FILE: src/isotp_tx_segmenter_unit.sv
// iso-tp transmit segmenter: packs message bytes into 8-byte can frames
// an accepted input beat is held in the input register and a frame it completes in the frame
// register; throughput: one input beat per cycle except when a completed frame is stalled;
// the two registers let a new beat enter while a finished frame waits downstream
// reset (i_rst_n low, synchronous) empties both registers, returns to idle with
// sequence number 1 and loads frame_id 0x703 and pad_value 0; the frame buffer is not cleared
module isotp_tx_segmenter_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration write channel
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [isotp_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [isotp_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // byte stream in
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [isotp_pkg::S_TDATA_W-1:0]          s_axis_tdata,  // data_byte, message_length
    input  logic                                     s_axis_tuser,  // start_of_message
    // frame stream out
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    output logic [isotp_pkg::M_TDATA_W-1:0]          m_axis_tdata,  // byte0..byte7, can_id
    output logic                                     m_axis_tlast   // last_frame
);

    localparam int NB   = isotp_pkg::BUF_DEPTH;
    localparam int FW   = isotp_pkg::FILL_W;
    localparam int LW   = isotp_pkg::LEN_W;
    localparam int SW   = isotp_pkg::SEQ_W;
    localparam int IW   = isotp_pkg::ID_W;
    localparam int PADW = isotp_pkg::M_TDATA_W - 8 * isotp_pkg::FRAME_BYTES - IW;

    // configuration registers
    logic [IW-1:0] r_frame_id;
    logic [7:0]    r_pad;

    // input register
    logic          r_in_valid;
    logic [7:0]    r_in_data;
    logic [LW-1:0] r_in_len;
    logic          r_in_start;

    // message state
    logic [7:0]        r_buf [NB];
    logic [FW-1:0]     r_fill;
    logic [LW-1:0]     r_remain;
    logic [SW-1:0]     r_seq;
    isotp_pkg::t_kind  r_kind;
    logic [LW-1:0]     r_len;

    // frame register
    logic          r_out_valid;
    logic [7:0]    r_out_bytes [isotp_pkg::FRAME_BYTES];
    logic [IW-1:0] r_out_id;
    logic          r_out_last;

    // combinational view of the current beat
    isotp_pkg::t_kind  c_kind0;
    logic [FW-1:0]     c_fill0;
    logic [FW-1:0]     n_fill;
    logic [LW-1:0]     c_rem0;
    logic [LW-1:0]     n_remain;
    logic [SW-1:0]     c_seq0;
    logic [LW-1:0]     c_len0;
    logic              c_zero;
    logic              c_active;
    logic              c_last;
    logic              c_done;
    logic              c_emit;
    logic              c_proc;
    logic              c_out_free;
    logic [7:0]        c_view [NB];
    logic [7:0]        n_bytes [isotp_pkg::FRAME_BYTES];
    logic              n_last;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_id <= isotp_pkg::FRAME_ID_RST;
            r_pad      <= isotp_pkg::PAD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                isotp_pkg::CFG_FRAME_ID: r_frame_id <= i_cfg_data[IW-1:0];
                isotp_pkg::CFG_PAD:      r_pad      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // handshake between the input register and the frame register
    assign c_out_free    = !r_out_valid || m_axis_tready;
    assign c_proc        = r_in_valid && (!c_emit || c_out_free);
    assign s_axis_tready = !r_in_valid || c_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (c_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data  <= s_axis_tdata[7:0];
            r_in_len   <= s_axis_tdata[8 +: LW];
            r_in_start <= s_axis_tuser;
        end
    end

    // effective state once a start beat has restarted the message
    always_comb begin
        c_zero   = r_in_start && (r_in_len == '0);
        c_fill0  = r_in_start ? '0 : r_fill;
        c_rem0   = r_in_start ? r_in_len : r_remain;
        c_seq0   = r_in_start ? isotp_pkg::SEQ_RST : r_seq;
        c_len0   = r_in_start ? r_in_len : r_len;
        if (!r_in_start) begin
            c_kind0 = r_kind;
        end else if (r_in_len == '0) begin
            c_kind0 = isotp_pkg::K_IDLE;
        end else if (r_in_len <= LW'(NB)) begin
            c_kind0 = isotp_pkg::K_SINGLE;
        end else begin
            c_kind0 = isotp_pkg::K_FIRST;
        end
        c_active = (c_kind0 != isotp_pkg::K_IDLE);
        n_fill   = (c_fill0 < FW'(NB)) ? c_fill0 + FW'(1) : c_fill0;
        n_remain = (c_rem0 != '0) ? c_rem0 - LW'(1) : c_rem0;
        c_last   = (n_remain == '0);
        case (c_kind0)
            isotp_pkg::K_SINGLE: c_done = c_last;
            isotp_pkg::K_FIRST:  c_done = (n_fill == FW'(isotp_pkg::FF_DATA));
            isotp_pkg::K_CONSEC: c_done = (n_fill == FW'(NB)) || c_last;
            default:             c_done = 1'b0;
        endcase
        c_emit = c_zero || (c_active && c_done);
    end

    // buffer slots with the incoming byte merged in, pad beyond the fill
    always_comb begin
        for (int k = 0; k < NB; k++) begin
            if (!c_zero && (FW'(k) < n_fill)) begin
                c_view[k] = (FW'(k) == c_fill0) ? r_in_data : r_buf[k];
            end else begin
                c_view[k] = r_pad;
            end
        end
    end

    // frame assembly
    always_comb begin
        n_bytes[0] = {isotp_pkg::PCI_SF, 4'h0};
        for (int k = 1; k < isotp_pkg::FRAME_BYTES; k++) begin
            n_bytes[k] = c_view[k-1];
        end
        n_last = 1'b1;
        if (!c_zero) begin
            case (c_kind0)
                isotp_pkg::K_SINGLE: begin
                    n_bytes[0] = {isotp_pkg::PCI_SF, c_len0[3:0]};
                end
                isotp_pkg::K_FIRST: begin
                    n_bytes[0] = {isotp_pkg::PCI_FF, c_len0[11:8]};
                    n_bytes[1] = c_len0[7:0];
                    for (int k = 2; k < isotp_pkg::FRAME_BYTES; k++) begin
                        n_bytes[k] = c_view[k-2];
                    end
                    n_last = c_last;
                end
                isotp_pkg::K_CONSEC: begin
                    n_bytes[0] = {isotp_pkg::PCI_CF, c_seq0};
                    n_last     = c_last;
                end
                default: ;
            endcase
        end
    end

    // buffer slot write, no reset
    always_ff @(posedge i_clk) begin
        if (c_proc && !c_zero && c_active && (c_fill0 < FW'(NB))) begin
            r_buf[c_fill0] <= r_in_data;
        end
    end

    // message state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_remain <= '0;
            r_seq    <= isotp_pkg::SEQ_RST;
            r_kind   <= isotp_pkg::K_IDLE;
            r_len    <= '0;
        end else if (c_proc) begin
            if (c_zero) begin
                r_fill   <= '0;
                r_remain <= '0;
                r_seq    <= isotp_pkg::SEQ_RST;
                r_kind   <= isotp_pkg::K_IDLE;
                r_len    <= '0;
            end else if (c_active) begin
                r_remain <= n_remain;
                r_len    <= c_len0;
                if (c_emit) begin
                    r_fill <= '0;
                    r_kind <= c_last ? isotp_pkg::K_IDLE : isotp_pkg::K_CONSEC;
                    r_seq  <= (c_kind0 == isotp_pkg::K_CONSEC) ? c_seq0 + SW'(1) : c_seq0;
                end else begin
                    r_fill <= n_fill;
                    r_kind <= c_kind0;
                    r_seq  <= c_seq0;
                end
            end
        end
    end

    // frame register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_proc && c_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_proc && c_emit) begin
            r_out_bytes <= n_bytes;
            r_out_id    <= r_frame_id;
            r_out_last  <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{PADW{1'b0}}, r_out_id,
                            r_out_bytes[7], r_out_bytes[6], r_out_bytes[5], r_out_bytes[4],
                            r_out_bytes[3], r_out_bytes[2], r_out_bytes[1], r_out_bytes[0]};

`ifndef SYNTHESIS
    // a single frame always closes its message
    a_sf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[7:4] == isotp_pkg::PCI_SF)) |-> m_axis_tlast)
        else $error("single frame without last flag");

    // a first frame never closes its message
    a_ff_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[7:4] == isotp_pkg::PCI_FF)) |-> !m_axis_tlast)
        else $error("first frame marked last");

    // no partial frame is held while idle
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind == isotp_pkg::K_IDLE) |-> (r_fill == '0))
        else $error("fill count nonzero while idle");

    // a first frame is sent before six bytes pile up
    a_ff_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind == isotp_pkg::K_FIRST) |-> (r_fill < FW'(isotp_pkg::FF_DATA)))
        else $error("first frame overfilled");

    // a frame is only loaded when the frame register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))
        else $error("frame overwritten while stalled");
`endif

endmodule
